// ===== rtl/lcp_pkg.sv =====
// Shared constants, types and the Life rule for the cell-pair stencil unit.
// No dependencies; imported by life_cell_pair_stencil_unit.
package lcp_pkg;

  localparam int MAX_COLS     = 63;
  localparam int MAX_ROWPAIRS = 32;

  localparam int COL_W  = 6;
  localparam int ROW_W  = 5;
  localparam int CFG_W  = 6;
  localparam int BYTE_W = 8;

  // Output tdata: new_byte, out_row, out_col, padded to whole bytes.
  localparam int OUT_FIELDS_W = BYTE_W + ROW_W + COL_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [0:0] {
    CFG_COLS = 1'b0,
    CFG_ROWS = 1'b1
  } cfg_reg_t;

  // One column of the 3x3 stencil: three row pairs of two cells each.
  // Bits [1:0] row pair above, [3:2] center row pair, [5:4] row pair below.
  // Within a pair, bit 0 is the upper cell and bit 1 the lower cell.
  typedef logic [5:0] stencil_col_t;

  // Result positions released by one source byte, in delivery order.
  typedef enum logic [1:0] {
    RES_PREV_LEFT  = 2'd0,
    RES_PREV_HERE  = 2'd1,
    RES_THIS_LEFT  = 2'd2,
    RES_THIS_HERE  = 2'd3
  } res_slot_t;

  function automatic logic life_rule(input logic alive, input logic [2:0] n);
    logic ok;
    begin
      ok = alive ? ((n == 3'd2) || (n == 3'd3)) : (n == 3'd3);
      return ok;
    end
  endfunction

  // Next state of the center pair; returns {lower alive, upper alive}.
  function automatic logic [1:0] life_pair(input stencil_col_t lft,
                                           input stencil_col_t mid,
                                           input stencil_col_t rgt);
    logic [2:0] side;
    logic [2:0] n_up;
    logic [2:0] n_lo;
    begin
      side = 3'(lft[2]) + 3'(lft[3]) + 3'(rgt[2]) + 3'(rgt[3]);
      n_up = side + 3'(mid[3]) + 3'(lft[1]) + 3'(mid[1]) + 3'(rgt[1]);
      n_lo = side + 3'(mid[2]) + 3'(lft[4]) + 3'(mid[4]) + 3'(rgt[4]);
      return {life_rule(mid[3], n_lo), life_rule(mid[2], n_up)};
    end
  endfunction

  // Recenters a column on its lower two row pairs; the row pair below is dead.
  function automatic stencil_col_t shift_down(input stencil_col_t col);
    return {2'b00, col[5:2]};
  endfunction

endpackage

// ===== rtl/life_cell_pair_stencil_unit.sv =====
// Life (B3/S23) generation engine over a raster stream of cell-pair bytes.
// A line memory keeps two row pairs per column; the Life rule is in lcp_pkg.
//
// Usage:
//   Source bytes enter on the s_ group in raster order (row pair 0 column 0
//   first). Each byte holds two stacked cells: low nibble upper, high nibble
//   lower, any set bit meaning alive. Results leave on the m_ group as the
//   next generation byte with its row pair and column. The byte at (r, c)
//   releases (r-1, c-1), plus (r-1, c) on the last column; on the last row
//   pair it also releases (r, c-1) and, on the last column, (r, c).
//   tlast marks the last result of a source beat, tuser the final result of
//   the generation. Cells outside the grid are dead.
// Timing:
//   Results pass stage 1 and the result group register. While m_tready is
//   high, one beat is taken per cycle if each releases at most one result,
//   and the output moves one result per cycle; a beat releasing more holds
//   the next beat with results until its last one leaves. A stalled receiver
//   backs up into s_tready after one buffered beat; nothing is dropped.
// Reset and configuration:
//   rst clears the position to row pair 0 column 0 and the registers to 40
//   columns and 24 row pairs. A register write also restarts the generation.
module life_cell_pair_stencil_unit
  import lcp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Configuration write port.
  input  logic                  cfg_we,
  input  logic [0:0]            cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  // Source stream. tdata: [7:0] cell_byte.
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [BYTE_W-1:0]     s_tdata,
  // Result stream. tdata: [7:0] new_byte, [12:8] out_row, [18:13] out_col,
  // zero fill above. tlast: last_of_run. tuser: frame_done.
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tlast,
  output logic                  m_tuser
);

  // Configuration and effective grid size.
  logic [CFG_W-1:0] cols_in_use;
  logic [CFG_W-1:0] rowpairs_in_use;
  logic [COL_W-1:0] last_col;
  logic [ROW_W-1:0] last_row;

  always_comb begin
    last_col = (cols_in_use == '0) ? '0 : cols_in_use - COL_W'(1);
    if (rowpairs_in_use == '0) begin
      last_row = '0;
    end else if (rowpairs_in_use > CFG_W'(MAX_ROWPAIRS)) begin
      last_row = ROW_W'(MAX_ROWPAIRS - 1);
    end else begin
      last_row = ROW_W'(rowpairs_in_use - CFG_W'(1));
    end
  end

  // Position of the next source beat.
  logic [COL_W-1:0] col_count;
  logic [ROW_W-1:0] row_count;

  // Line memory: [3:2] newest row pair written at this column, [1:0] the one before.
  logic [3:0] line_mem [MAX_COLS];
  logic [3:0] rd_data;

  // Stage 1: beat whose line memory data is now available.
  logic             s1_valid;
  logic [1:0]       s1_cells;
  logic [ROW_W-1:0] s1_r;
  logic [COL_W-1:0] s1_c;
  logic             s1_go;

  // Stencil window: the two columns left of the current one.
  stencil_col_t win1;
  stencil_col_t win2;

  // Result group waiting for the output port.
  logic [3:0]       grp_mask;
  logic [1:0]       grp_cells [4];
  logic [ROW_W-1:0] grp_r;
  logic [COL_W-1:0] grp_c;

  logic in_acc;
  logic out_pop;

  // Current column and the results it releases.
  stencil_col_t cur_col;
  stencil_col_t left1;
  stencil_col_t left2;
  logic [1:0]   res_cells [4];
  logic [3:0]   new_mask;
  logic [3:0]   wr_data;

  always_comb begin
    cur_col = {s1_cells,
               (s1_r != '0) ? rd_data[3:2] : 2'b00,
               (s1_r > ROW_W'(1)) ? rd_data[1:0] : 2'b00};
    left1 = (s1_c != '0) ? win1 : '0;
    left2 = (s1_c > COL_W'(1)) ? win2 : '0;
    res_cells[RES_PREV_LEFT] = life_pair(left2, left1, cur_col);
    res_cells[RES_PREV_HERE] = life_pair(left1, cur_col, '0);
    res_cells[RES_THIS_LEFT] = life_pair(shift_down(left2), shift_down(left1),
                                         shift_down(cur_col));
    res_cells[RES_THIS_HERE] = life_pair(shift_down(left1), shift_down(cur_col), '0);
    new_mask[RES_PREV_LEFT] = (s1_r != '0) && (s1_c != '0);
    new_mask[RES_PREV_HERE] = (s1_r != '0) && (s1_c == last_col);
    new_mask[RES_THIS_LEFT] = (s1_r == last_row) && (s1_c != '0);
    new_mask[RES_THIS_HERE] = (s1_r == last_row) && (s1_c == last_col);
    wr_data = {s1_cells, rd_data[3:2]};
  end

  // Output selection: lowest pending slot goes first.
  res_slot_t  sel;
  logic [3:0] rest_mask;
  logic       grp_free;

  always_comb begin
    if (grp_mask[RES_PREV_LEFT]) begin
      sel = RES_PREV_LEFT;
    end else if (grp_mask[RES_PREV_HERE]) begin
      sel = RES_PREV_HERE;
    end else if (grp_mask[RES_THIS_LEFT]) begin
      sel = RES_THIS_LEFT;
    end else begin
      sel = RES_THIS_HERE;
    end
    rest_mask = grp_mask & ~(4'b0001 << sel);
  end

  always_comb begin
    m_tvalid = (grp_mask != '0);
    m_tlast  = (rest_mask == '0);
    m_tuser  = (sel == RES_THIS_HERE);
    m_tdata  = '0;
    m_tdata[BYTE_W-1:0] = {{4{grp_cells[sel][1]}}, {4{grp_cells[sel][0]}}};
    m_tdata[BYTE_W +: ROW_W] = (sel == RES_PREV_LEFT || sel == RES_PREV_HERE) ?
                               grp_r - ROW_W'(1) : grp_r;
    m_tdata[BYTE_W+ROW_W +: COL_W] = (sel == RES_PREV_LEFT || sel == RES_THIS_LEFT) ?
                                     grp_c - COL_W'(1) : grp_c;
  end

  assign out_pop  = m_tvalid && m_tready;
  assign grp_free = (grp_mask == '0) || (m_tready && rest_mask == '0);
  assign s1_go    = s1_valid && ((new_mask == '0) || grp_free);
  assign s_tready = !s1_valid || s1_go;
  assign in_acc   = s_tvalid && s_tready;

  // Configuration registers and position counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      cols_in_use     <= CFG_W'(40);
      rowpairs_in_use <= CFG_W'(24);
      col_count       <= '0;
      row_count       <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_COLS: cols_in_use     <= cfg_data;
        CFG_ROWS: rowpairs_in_use <= cfg_data;
        default:  ;
      endcase
      col_count <= '0;
      row_count <= '0;
    end else if (in_acc) begin
      if (col_count == last_col) begin
        col_count <= '0;
        row_count <= (row_count == last_row) ? '0 : row_count + ROW_W'(1);
      end else begin
        col_count <= col_count + COL_W'(1);
      end
    end
  end

  // Line memory. A read of the column written in the same cycle takes the new data.
  always_ff @(posedge clk) begin
    if (s1_go) begin
      line_mem[s1_c] <= wr_data;
    end
    if (in_acc) begin
      if (s1_go && (s1_c == col_count)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= line_mem[col_count];
      end
    end
  end

  // Stage 1 and window.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cells <= {(s_tdata[7:4] != '0), (s_tdata[3:0] != '0)};
      s1_r     <= row_count;
      s1_c     <= col_count;
    end
    if (s1_go) begin
      win2 <= win1;
      win1 <= cur_col;
    end
  end

  // Result group.
  always_ff @(posedge clk) begin
    if (rst) begin
      grp_mask <= '0;
    end else if (s1_go && (new_mask != '0)) begin
      grp_mask <= new_mask;
    end else if (out_pop) begin
      grp_mask <= rest_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && (new_mask != '0)) begin
      grp_cells <= res_cells;
      grp_r     <= s1_r;
      grp_c     <= s1_c;
    end
  end

  // Checks.
  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    (col_count <= last_col) && (row_count <= last_row))
    else $error("source position outside the configured grid");

  a_s1_in_range: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (s1_c <= last_col) && (s1_r <= last_row))
    else $error("line memory access outside the configured columns");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (s1_go && (new_mask != '0) && (grp_mask != '0)) |-> (out_pop && rest_mask == '0))
    else $error("result group replaced before it was delivered");

  a_frame_end_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> m_tlast)
    else $error("generation end not on the last result of its beat");

  a_frame_wraps: assert property (@(posedge clk) disable iff (rst)
    (out_pop && m_tuser) |-> (grp_r == last_row) && (grp_c == last_col))
    else $error("generation end flagged away from the last cell");

endmodule
